[hdl/usrng_pkg.sv]
package usrng_pkg;

	// Width of the echo tick counter; the count saturates at its all-ones value.
	localparam int COUNT_WIDTH = 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam int TICK_W = 16;
	localparam int RANGE_W = 11;
	localparam logic [RANGE_W-1:0] RANGE_MAX = 11'd2047;

	// Distance is count * 17 / 1000, kept as a running quotient and remainder.
	localparam logic [10:0] CM_STEP = 11'd17;
	localparam logic [10:0] CM_DIV = 11'd1000;

	localparam logic [TICK_W-1:0] TRIG_TICKS_RST = 16'd2000;
	localparam logic [TICK_W-1:0] HOLD_TICKS_RST = 16'd1000;

	localparam logic REG_TRIG_TICKS = 1'b0;
	localparam logic REG_HOLD_TICKS = 1'b1;

	localparam logic [3:0] SEL_NONE = 4'hF;
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	typedef enum logic [3:0] {
		PH_TRIGGER = 4'b0001,
		PH_WAIT    = 4'b0010,
		PH_MEASURE = 4'b0100,
		PH_SCAN    = 4'b1000
	} phase_t;

	// Sequencer view handed to the measurement datapath and the output stage.
	typedef struct packed {
		phase_t     phase;
		logic [1:0] pos;
		logic       start;
		logic       count;
		logic       latch;
	} ctrl_t;

	// Active-low seven-segment pattern, bit 0 is segment a, point always off.
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'hC0;
			4'd1: seg = 8'hF9;
			4'd2: seg = 8'hA4;
			4'd3: seg = 8'hB0;
			4'd4: seg = 8'h99;
			4'd5: seg = 8'h92;
			4'd6: seg = 8'h82;
			4'd7: seg = 8'hF8;
			4'd8: seg = 8'h80;
			4'd9: seg = 8'h90;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

	// Active-low digit select, units digit first.
	function automatic logic [3:0] sel_of(input logic [1:0] pos);
		logic [3:0] sel;
		case (pos)
			2'd0: sel = 4'h7;
			2'd1: sel = 4'hB;
			2'd2: sel = 4'hD;
			2'd3: sel = 4'hE;
			default: sel = SEL_NONE;
		endcase
		return sel;
	endfunction

endpackage

[hdl/usrng_ctrl.sv]
module usrng_ctrl import usrng_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              echo,
	input  logic [TICK_W-1:0] trig_ticks,
	input  logic [TICK_W-1:0] hold_ticks,
	output ctrl_t             ctrl
);

	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] ticks_q, ticks_d;
	logic [1:0]        pos_q, pos_d;
	logic [TICK_W-1:0] limit;
	logic              at_end;

	// A limit of zero behaves as one tick.
	always_comb begin
		if (phase_q == PH_SCAN) begin
			limit = (hold_ticks == '0) ? TICK_W'(1) : hold_ticks;
		end else begin
			limit = (trig_ticks == '0) ? TICK_W'(1) : trig_ticks;
		end
		at_end = ({1'b0, ticks_q} + (TICK_W+1)'(1)) >= {1'b0, limit};
	end

	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		pos_d = pos_q;
		ctrl.start = 1'b0;
		ctrl.count = 1'b0;
		ctrl.latch = 1'b0;
		case (phase_q)
			PH_TRIGGER: begin
				if (at_end) begin
					phase_d = PH_WAIT;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_q + TICK_W'(1);
				end
			end
			PH_WAIT: begin
				if (echo) begin
					ctrl.start = 1'b1;
					phase_d = PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (echo) begin
					ctrl.count = 1'b1;
				end else begin
					ctrl.latch = 1'b1;
					phase_d = PH_SCAN;
					ticks_d = '0;
					pos_d = '0;
				end
			end
			PH_SCAN: begin
				if (at_end) begin
					ticks_d = '0;
					pos_d = pos_q + 2'd1;
					if (pos_q == 2'd3) begin
						phase_d = PH_TRIGGER;
					end
				end else begin
					ticks_d = ticks_q + TICK_W'(1);
				end
			end
			default: begin
				phase_d = PH_TRIGGER;
				ticks_d = '0;
				pos_d = '0;
			end
		endcase
		ctrl.phase = phase_q;
		ctrl.pos = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRIGGER;
			ticks_q <= '0;
			pos_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			pos_q <= pos_d;
		end
	end

endmodule

[hdl/usrng_meas.sv]
module usrng_meas import usrng_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  ctrl_t              ctrl,
	output logic [RANGE_W-1:0] range_next,
	output logic [3:0]         digit,
	output logic [9:0]         rem
);

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [RANGE_W-1:0]     quo_q, range_q;
	logic [9:0]             rem_q;
	logic [3:0]             bcd_q [4];
	logic [3:0]             dig_q [4];
	logic [10:0]            rem_sum;
	logic                   carry;
	logic [3:0]             bcd_inc [4];
	logic                   c;

	// The quotient moves up by one whenever the remainder passes the divisor, unless it is already at its maximum.
	always_comb begin
		rem_sum = {1'b0, rem_q} + CM_STEP;
		carry = (rem_sum >= CM_DIV) && (quo_q != RANGE_MAX);
		c = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (c && bcd_q[i] == 4'd9) begin
				bcd_inc[i] = 4'd0;
			end else begin
				bcd_inc[i] = bcd_q[i] + {3'd0, c};
				c = 1'b0;
			end
		end
		range_next = ctrl.latch ? quo_q : range_q;
		digit = dig_q[ctrl.pos];
		rem = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			range_q <= '0;
			for (int i = 0; i < 4; i++) begin
				bcd_q[i] <= '0;
				dig_q[i] <= '0;
			end
		end else if (step) begin
			if (ctrl.start) begin
				cnt_q <= COUNT_WIDTH'(1);
				quo_q <= '0;
				rem_q <= CM_STEP[9:0];
				for (int i = 0; i < 4; i++) begin
					bcd_q[i] <= '0;
				end
			end else if (ctrl.count && cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + COUNT_WIDTH'(1);
				if (rem_sum >= CM_DIV) begin
					rem_q <= 10'(rem_sum - CM_DIV);
				end else begin
					rem_q <= rem_sum[9:0];
				end
				if (carry) begin
					quo_q <= quo_q + RANGE_W'(1);
					for (int i = 0; i < 4; i++) begin
						bcd_q[i] <= bcd_inc[i];
					end
				end
			end else if (ctrl.latch) begin
				range_q <= quo_q;
				cnt_q <= '0;
				for (int i = 0; i < 4; i++) begin
					dig_q[i] <= bcd_q[i];
				end
			end
		end
	end

endmodule

[hdl/ultrasonic_ranger_with_digit_scan.sv]
// The result word for an accepted echo word is registered in the output register.
// Throughput: one word per cycle while the output register is empty or not stalled,
// set by the single output register that the sequencer and the distance datapath both
// update in the accepting cycle.
// Reset: asynchronous, active low; the block starts in the trigger phase with zero stored
// distance, the result word is not reset, and the tick limits return to 2000 and 1000.
module ultrasonic_ranger_with_digit_scan import usrng_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               echo,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               trigger,
	output logic [3:0]         digit_enable_n,
	output logic [7:0]         segments_n,
	output logic [RANGE_W-1:0] distance_cm,
	output logic               measure_done,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [TICK_W-1:0]  cfg_data
);

	// Configuration registers. They are to be written only while the block is idle; the block does not enforce it.
	logic [TICK_W-1:0] trig_ticks_q;
	logic [TICK_W-1:0] hold_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= TRIG_TICKS_RST;
			hold_ticks_q <= HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIG_TICKS: trig_ticks_q <= cfg_data;
				REG_HOLD_TICKS: hold_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake. The output register takes a new word whenever it is empty or its
	// current word leaves in the same cycle, so a tick can be accepted every cycle.
	logic out_valid_q;
	logic accept;

	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// The sequencer walks the trigger, wait, measure and scan phases, one step per
	// accepted tick. It reports which phase the current tick is in and which
	// measurement event the tick causes.
	ctrl_t ctrl;

	usrng_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.echo       (echo),
		.trig_ticks (trig_ticks_q),
		.hold_ticks (hold_ticks_q),
		.ctrl       (ctrl)
	);

	// The distance datapath keeps count * 17 / 1000 as a running quotient and
	// remainder while echo is high, so no divider is needed. The quotient is kept
	// in decimal digits too, ready for the scan that follows the latch.
	logic [RANGE_W-1:0] range_next;
	logic [3:0]         digit;
	logic [9:0]         rem;

	usrng_meas u_meas (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.ctrl       (ctrl),
		.range_next (range_next),
		.digit      (digit),
		.rem        (rem)
	);

	// Result word. The trigger is high through the trigger phase, a digit is shown
	// only during the scan, and the distance field carries the value after the tick.
	logic       trigger_q;
	logic [3:0] digit_enable_n_q;
	logic [7:0] segments_n_q;
	logic [RANGE_W-1:0] distance_cm_q;
	logic       measure_done_q;
	logic       scan;

	assign scan = (ctrl.phase == PH_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trigger_q <= (ctrl.phase == PH_TRIGGER);
			digit_enable_n_q <= scan ? sel_of(ctrl.pos) : SEL_NONE;
			segments_n_q <= scan ? seg_of(digit) : SEG_BLANK;
			distance_cm_q <= range_next;
			measure_done_q <= ctrl.latch;
		end
	end

	assign trigger = trigger_q;
	assign digit_enable_n = digit_enable_n_q;
	assign segments_n = segments_n_q;
	assign distance_cm = distance_cm_q;
	assign measure_done = measure_done_q;

`ifndef SYNTHESIS
	// The running remainder always stays below the divisor.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem < CM_DIV[9:0])
		else $error("distance remainder out of range");

	// A latched distance is followed by the scan phase.
	a_latch_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctrl.latch |=> ctrl.phase == PH_SCAN)
		else $error("latch did not start the scan");

	// No digit is lit while the trigger is driven or a distance is latched.
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (trigger || measure_done) |->
			digit_enable_n == SEL_NONE && segments_n == SEG_BLANK)
		else $error("digit lit outside the scan");

	// Trigger and latch never come from the same tick.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(trigger && measure_done))
		else $error("trigger and measure done together");
`endif

endmodule
